// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define PRTD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PRTD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/prtd_pkg.sv =====
package prtd_pkg;

	localparam int CFG_W = 7;
	localparam int BYTE_W = 8;
	localparam int OFF_W = 14;
	localparam int LEN_W = 13;
	localparam int KIND_W = 2;
	localparam int RUN_W = 8;
	localparam int PLANE_W = 3;
	localparam int CHAN_W = 2;
	localparam int CHANNELS = 4;

	localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;
	localparam logic [6:0] COUNT_MASK = 7'h7f;
	localparam int REPEAT_BIT = 7;

	// Register indexes on the configuration port.
	localparam logic REG_TILE_WIDTH = 1'b0;
	localparam logic REG_TILE_HEIGHT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OVERRUN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_REPEAT,
		PH_LITERAL
	} phase_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic [BYTE_W-1:0] value;
		logic [KIND_W-1:0] kind;
		logic done;
	} res_t;

endpackage

// ===== hdl/planar_rle_tile_decoder.sv =====
// Channel  Handshake              Payload
// in       in_valid/in_ready      data_byte, last_byte
// out      out_valid/out_ready    dest_offset, run_length, fill_value, run_kind, tile_done
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One compressed byte is taken per cycle while in_ready is high; each byte yields at most one decoded run.
// A byte that ends the input is followed by one zero-fill run per plane still to be filled (up to
// four), since the single result path carries one run at a time; input is held until they are done.
// Results go through an output register and a skid register; input stalls while the skid
// register is occupied. After reset and after each register write, input is held while the
// registered plane size settles.
module planar_rle_tile_decoder #(
	parameter int MAX_TILE_SIDE = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [prtd_pkg::BYTE_W-1:0] data_byte,
	input  logic last_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [prtd_pkg::OFF_W-1:0] dest_offset,
	output logic [prtd_pkg::LEN_W-1:0] run_length,
	output logic [prtd_pkg::BYTE_W-1:0] fill_value,
	output logic [prtd_pkg::KIND_W-1:0] run_kind,
	output logic tile_done,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [prtd_pkg::CFG_W-1:0] cfg_data
);

	localparam int SIDE_W = $clog2(MAX_TILE_SIDE + 1);
	localparam int CMP_W = (SIDE_W > prtd_pkg::CFG_W) ? SIDE_W : prtd_pkg::CFG_W;
	localparam int PIX_W = 2 * SIDE_W;
	localparam int RW = (PIX_W > 9) ? PIX_W : 9;
	localparam int WIDE_W = PIX_W + prtd_pkg::CHAN_W;
	localparam logic [prtd_pkg::PLANE_W-1:0] PLANES = prtd_pkg::PLANE_W'(prtd_pkg::CHANNELS);
	localparam logic [prtd_pkg::PLANE_W-1:0] PLANE_LAST =
		prtd_pkg::PLANE_W'(prtd_pkg::CHANNELS - 1);

	logic [prtd_pkg::CFG_W-1:0] tile_width_q, tile_height_q;
	logic [PIX_W-1:0] psize_q;
	logic cfg_hold_q;
	logic fill_q, nxt_fill;
	prtd_pkg::phase_t phase_q, nxt_phase;
	logic [prtd_pkg::RUN_W-1:0] run_q, nxt_run;
	logic [prtd_pkg::PLANE_W-1:0] plane_q, nxt_plane;
	logic [PIX_W-1:0] pix_q, nxt_pix;

	logic [CMP_W-1:0] w_ext, h_ext;
	logic [SIDE_W-1:0] side_w, side_h;
	logic [PIX_W-1:0] room, pix_step;
	logic [RW-1:0] count_ext, room_ext;
	logic [prtd_pkg::CHAN_W-1:0] chan;
	logic [WIDE_W-1:0] offset_wide;
	logic cfg_fire, in_fire, push, pop;
	prtd_pkg::res_t res;
	prtd_pkg::res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid;
	assign in_ready = !skid_valid_q && !fill_q && !cfg_hold_q;
	assign in_fire = in_valid && in_ready;
	assign pop = out_valid_q && out_ready;

	// Plane size from the clamped sides, registered to keep the multiplier off the decode path.
	always_comb begin
		w_ext = CMP_W'(tile_width_q);
		h_ext = CMP_W'(tile_height_q);
		if (w_ext == '0) begin
			side_w = SIDE_W'(1);
		end else if (w_ext > CMP_W'(MAX_TILE_SIDE)) begin
			side_w = SIDE_W'(MAX_TILE_SIDE);
		end else begin
			side_w = SIDE_W'(w_ext);
		end
		if (h_ext == '0) begin
			side_h = SIDE_W'(1);
		end else if (h_ext > CMP_W'(MAX_TILE_SIDE)) begin
			side_h = SIDE_W'(MAX_TILE_SIDE);
		end else begin
			side_h = SIDE_W'(h_ext);
		end
	end

	always_ff @(posedge clk) begin
		psize_q <= PIX_W'(side_w) * PIX_W'(side_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q <= prtd_pkg::SIDE_RESET;
			tile_height_q <= prtd_pkg::SIDE_RESET;
			cfg_hold_q <= 1'b1;
		end else begin
			cfg_hold_q <= cfg_fire;
			if (cfg_fire && cfg_index == prtd_pkg::REG_TILE_WIDTH) begin
				tile_width_q <= cfg_data;
			end
			if (cfg_fire && cfg_index == prtd_pkg::REG_TILE_HEIGHT) begin
				tile_height_q <= cfg_data;
			end
		end
	end

	always_comb begin
		nxt_phase = phase_q;
		nxt_run = run_q;
		nxt_plane = plane_q;
		nxt_pix = pix_q;
		nxt_fill = fill_q;
		push = 1'b0;
		room = psize_q - pix_q;
		room_ext = RW'(room);
		count_ext = RW'({1'b0, data_byte[6:0] & prtd_pkg::COUNT_MASK}) + RW'(1);
		chan = prtd_pkg::CHAN_W'(prtd_pkg::CHANNELS - 1) - plane_q[prtd_pkg::CHAN_W-1:0];
		offset_wide = (WIDE_W'(pix_q) << prtd_pkg::CHAN_W) | WIDE_W'(chan);
		pix_step = pix_q + PIX_W'(run_q);
		res.offset = prtd_pkg::OFF_W'(offset_wide);
		res.length = prtd_pkg::LEN_W'(room);
		res.value = '0;
		res.kind = prtd_pkg::KIND_END;
		res.done = 1'b0;

		if (cfg_fire) begin
			nxt_phase = prtd_pkg::PH_HEADER;
			nxt_run = '0;
			nxt_plane = '0;
			nxt_pix = '0;
			nxt_fill = 1'b0;
		end else if (fill_q) begin
			// One zero-fill transaction per plane left at end of input.
			if (!skid_valid_q) begin
				push = 1'b1;
				res.done = (plane_q == PLANE_LAST);
				if (plane_q == PLANE_LAST) begin
					nxt_phase = prtd_pkg::PH_HEADER;
					nxt_run = '0;
					nxt_plane = '0;
					nxt_pix = '0;
					nxt_fill = 1'b0;
				end else begin
					nxt_plane = plane_q + 1'b1;
					nxt_pix = '0;
				end
			end
		end else if (in_fire) begin
			if (plane_q < PLANES) begin
				case (phase_q)
					prtd_pkg::PH_REPEAT: begin
						push = 1'b1;
						res.length = prtd_pkg::LEN_W'(run_q);
						res.value = data_byte;
						res.kind = prtd_pkg::KIND_DATA;
						nxt_pix = pix_step;
						nxt_run = '0;
						nxt_phase = prtd_pkg::PH_HEADER;
						if (pix_step >= psize_q) begin
							nxt_plane = plane_q + 1'b1;
							nxt_pix = '0;
						end
					end
					prtd_pkg::PH_LITERAL: begin
						push = 1'b1;
						res.length = prtd_pkg::LEN_W'(1);
						res.value = data_byte;
						res.kind = prtd_pkg::KIND_DATA;
						nxt_pix = pix_q + PIX_W'(1);
						if (run_q != '0) begin
							nxt_run = run_q - 1'b1;
						end
						if (run_q <= prtd_pkg::RUN_W'(1)) begin
							nxt_phase = prtd_pkg::PH_HEADER;
							if (pix_q + PIX_W'(1) >= psize_q) begin
								nxt_plane = plane_q + 1'b1;
								nxt_pix = '0;
								nxt_run = '0;
							end
						end
					end
					default: begin
						if (count_ext > room_ext) begin
							// Run would spill past the plane: zero the rest and move on.
							push = 1'b1;
							res.kind = prtd_pkg::KIND_OVERRUN;
							nxt_plane = plane_q + 1'b1;
							nxt_pix = '0;
							nxt_run = '0;
							nxt_phase = prtd_pkg::PH_HEADER;
						end else begin
							nxt_phase = data_byte[prtd_pkg::REPEAT_BIT] ?
								prtd_pkg::PH_REPEAT : prtd_pkg::PH_LITERAL;
							nxt_run = prtd_pkg::RUN_W'(count_ext);
						end
					end
				endcase
			end
			res.done = (nxt_plane == PLANES);
			if (last_byte) begin
				if (nxt_plane < PLANES) begin
					nxt_fill = 1'b1;
				end else begin
					nxt_phase = prtd_pkg::PH_HEADER;
					nxt_run = '0;
					nxt_plane = '0;
					nxt_pix = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= prtd_pkg::PH_HEADER;
			run_q <= '0;
			plane_q <= '0;
			pix_q <= '0;
			fill_q <= 1'b0;
		end else begin
			phase_q <= nxt_phase;
			run_q <= nxt_run;
			plane_q <= nxt_plane;
			pix_q <= nxt_pix;
			fill_q <= nxt_fill;
		end
	end

	// Output register with a skid register behind it; a push only happens when the skid is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign dest_offset = out_q.offset;
	assign run_length = out_q.length;
	assign fill_value = out_q.value;
	assign run_kind = out_q.kind;
	assign tile_done = out_q.done;

endmodule

// ===== hdl/prtd_checker.sv =====
`include "assert_macros.svh"

module prtd_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [prtd_pkg::OFF_W-1:0] dest_offset,
	input logic [prtd_pkg::LEN_W-1:0] run_length,
	input logic [prtd_pkg::BYTE_W-1:0] fill_value,
	input logic [prtd_pkg::KIND_W-1:0] run_kind,
	input logic tile_done
);

	// A stalled result transaction keeps its payload.
	`PRTD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(dest_offset) && $stable(run_length) && $stable(fill_value) && $stable(run_kind) && $stable(tile_done), "result changed while stalled")

	`PRTD_ASSERT(a_len_nonzero, out_valid |-> run_length != '0, "result with zero length")

	// Fills always write zero.
	`PRTD_ASSERT(a_fill_zero, out_valid && run_kind != prtd_pkg::KIND_DATA |-> fill_value == '0, "zero fill with nonzero value")

	`PRTD_ASSERT(a_kind_legal, out_valid |-> run_kind == prtd_pkg::KIND_DATA || run_kind == prtd_pkg::KIND_OVERRUN || run_kind == prtd_pkg::KIND_END, "unknown run kind")

	// Reset may be low from the start without an edge, so the first reset clock clears it.
	`PRTD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "result valid during reset")

endmodule

bind planar_rle_tile_decoder prtd_checker u_prtd_checker (.*);

// ===== test/testbench.sv =====
module testbench;
	import prtd_pkg::*;

	localparam int TILE_SIDE_MAX = 64;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_BYTES = 80;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic last;
	} byte_item_t;

	typedef struct packed {
		logic idx;
		logic [CFG_W-1:0] value;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OFF_W-1:0] dest_offset;
	logic [LEN_W-1:0] run_length;
	logic [BYTE_W-1:0] fill_value;
	logic [KIND_W-1:0] run_kind;
	logic tile_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	byte_item_t byte_queue[$];
	reg_write_t cfg_queue[$];
	res_t expected_runs[$];

	// Decoder state as predicted from the accepted transactions.
	logic [CFG_W-1:0] size_w;
	logic [CFG_W-1:0] size_h;
	phase_t dec_phase;
	logic [RUN_W-1:0] run_left;
	logic [PLANE_W-1:0] plane_idx;
	logic [12:0] pixel_pos;

	// Tile size as seen by the stimulus generator.
	logic [CFG_W-1:0] gen_w = SIDE_RESET;
	logic [CFG_W-1:0] gen_h = SIDE_RESET;

	logic calm = 1'b0;
	logic squeeze_req = 1'b0;
	logic squeeze_taken;
	int send_gap;
	int recv_wait;
	int hold_left;
	int fault_count = 0;

	planar_rle_tile_decoder #(
		.MAX_TILE_SIDE(TILE_SIDE_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_offset(dest_offset),
		.run_length(run_length),
		.fill_value(fill_value),
		.run_kind(run_kind),
		.tile_done(tile_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int side_of(logic [CFG_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > TILE_SIDE_MAX)
			return TILE_SIDE_MAX;
		return s;
	endfunction

	function automatic void restart_decode();
		dec_phase = PH_HEADER;
		run_left = '0;
		plane_idx = '0;
		pixel_pos = '0;
	endfunction

	function automatic logic advance_plane();
		plane_idx = plane_idx + 1'b1;
		pixel_pos = '0;
		dec_phase = PH_HEADER;
		run_left = '0;
		return plane_idx >= CHANNELS;
	endfunction

	function automatic void note_run(int len, logic [BYTE_W-1:0] val, logic [KIND_W-1:0] kind);
		res_t r;
		r.offset = OFF_W'(int'(pixel_pos) * CHANNELS + (CHANNELS - 1 - int'(plane_idx)));
		r.length = LEN_W'(len);
		r.value = val;
		r.kind = kind;
		r.done = 1'b0;
		expected_runs.push_back(r);
	endfunction

	function automatic void decode_byte(logic [BYTE_W-1:0] b, logic last);
		int psize;
		int count;
		int room;
		int mark;
		logic finished;
		res_t r;
		psize = side_of(size_w) * side_of(size_h);
		finished = 1'b0;
		mark = expected_runs.size();
		if (plane_idx < CHANNELS) begin
			case (dec_phase)
				PH_REPEAT: begin
					note_run(run_left, b, KIND_DATA);
					pixel_pos = pixel_pos + run_left;
					run_left = '0;
					dec_phase = PH_HEADER;
					if (pixel_pos >= psize)
						finished = advance_plane();
				end
				PH_LITERAL: begin
					note_run(1, b, KIND_DATA);
					pixel_pos = pixel_pos + 1'b1;
					if (run_left != 0)
						run_left = run_left - 1'b1;
					if (run_left == 0) begin
						dec_phase = PH_HEADER;
						if (pixel_pos >= psize)
							finished = advance_plane();
					end
				end
				default: begin
					count = int'(b[6:0] & COUNT_MASK) + 1;
					room = psize - int'(pixel_pos);
					if (count > room) begin
						note_run(room, '0, KIND_OVERRUN);
						finished = advance_plane();
					end else begin
						dec_phase = b[REPEAT_BIT] ? PH_REPEAT : PH_LITERAL;
						run_left = RUN_W'(count);
					end
				end
			endcase
		end
		if (last) begin
			while (plane_idx < CHANNELS) begin
				note_run(psize - int'(pixel_pos), '0, KIND_END);
				finished = advance_plane();
			end
			restart_decode();
		end
		if (finished && expected_runs.size() > mark) begin
			r = expected_runs.pop_back();
			r.done = 1'b1;
			expected_runs.push_back(r);
		end
	endfunction

	// Sender side: compressed bytes and register writes, plus the prediction at acceptance.
	always @(posedge clk or negedge arst_n) begin
		byte_item_t nxt;
		reg_write_t wr;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			last_byte <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_index <= 1'b0;
			cfg_data <= '0;
			send_gap <= 0;
			size_w = SIDE_RESET;
			size_h = SIDE_RESET;
			restart_decode();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TILE_WIDTH)
					size_w = cfg_data;
				else if (cfg_index == REG_TILE_HEIGHT)
					size_h = cfg_data;
				restart_decode();
			end
			if (in_valid && in_ready)
				decode_byte(data_byte, last_byte);

			if (cfg_valid && !cfg_ready) begin
				// Hold the write until it is taken.
			end else if (cfg_queue.size() != 0) begin
				wr = cfg_queue.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= wr.idx;
				cfg_data <= wr.value;
			end else begin
				cfg_valid <= 1'b0;
			end

			// The gap drawn with an item is waited out after that item is taken.
			if (in_valid && !in_ready) begin
			end else if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (byte_queue.size() != 0) begin
				nxt = byte_queue.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.value;
				last_byte <= nxt.last;
				send_gap <= calm ? 0 : $urandom_range(0, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver side: checks each run transaction and paces out_ready.
	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t wanted;
		int stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			hold_left <= 0;
			squeeze_taken <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {dest_offset, run_length, fill_value, run_kind, tile_done};
				if (expected_runs.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected run: offset %0d length %0d value %0h kind %0d done %0b",
							seen.offset, seen.length, seen.value, seen.kind, seen.done);
					fault_count++;
				end else begin
					wanted = expected_runs.pop_front();
					if (seen.offset !== wanted.offset || seen.length !== wanted.length ||
						seen.value !== wanted.value || seen.kind !== wanted.kind ||
						seen.done !== wanted.done) begin
						if (fault_count < 10)
							$display("run mismatch (expected/actual): offset %0d/%0d length %0d/%0d %s",
								wanted.offset, seen.offset, wanted.length, seen.length,
								$sformatf("value %0h/%0h kind %0d/%0d done %0b/%0b",
									wanted.value, seen.value, wanted.kind, seen.kind,
									wanted.done, seen.done));
						fault_count++;
					end
				end
			end

			if (squeeze_req && !squeeze_taken) begin
				squeeze_taken <= 1'b1;
				hold_left <= HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				stall = calm ? 0 : $urandom_range(0, 9);
				recv_wait <= stall;
				out_ready <= (stall == 0);
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
		byte_queue.push_back({value, last});
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		if (idx == REG_TILE_WIDTH)
			gen_w = value;
		else
			gen_h = value;
		cfg_queue.push_back({idx, value});
	endtask

	// Waits until every transaction is through and then lets the block drain.
	task automatic settle();
		do
			@(negedge clk);
		while (byte_queue.size() != 0 || cfg_queue.size() != 0 || in_valid || cfg_valid ||
			expected_runs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_side();
		if ($urandom_range(0, 3) == 0)
			return CFG_W'($urandom_range(0, 127));
		return CFG_W'($urandom_range(1, 6));
	endfunction

	// Builds one tile stream: mostly well-formed runs, now and then an overrunning
	// header, a random cut with the last byte, bytes after completion, or plain noise.
	task automatic queue_tile(input int psize, output int counted);
		byte_item_t tile[$];
		byte_item_t tail;
		int budget;
		int p;
		int pos;
		int room;
		int count;
		int sel;
		int span;
		budget = $urandom_range(3, 40);
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(2, 10))
				tile.push_back({8'($urandom), 1'b0});
		end else begin
			for (p = 0; p < CHANNELS; p++) begin
				pos = 0;
				while (pos < psize) begin
					room = psize - pos;
					sel = $urandom_range(0, 15);
					if (sel == 0 && room < 128) begin
						tile.push_back({1'($urandom_range(0, 1)), 7'($urandom_range(room, 127)),
							1'b0});
						pos = psize;
					end else if (sel < 9) begin
						count = $urandom_range(1, (room < 128) ? room : 128);
						tile.push_back({1'b1, 7'(count - 1), 1'b0});
						tile.push_back({8'($urandom), 1'b0});
						pos += count;
					end else begin
						span = (sel == 15) ? 128 : 8;
						count = $urandom_range(1, (room < span) ? room : span);
						tile.push_back({1'b0, 7'(count - 1), 1'b0});
						repeat (count)
							tile.push_back({8'($urandom), 1'b0});
						pos += count;
					end
				end
			end
		end
		while (tile.size() > budget)
			void'(tile.pop_back());
		counted = tile.size();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				tile.push_back({8'($urandom), 1'b0});
		tail = tile.pop_back();
		tail.last = 1'b1;
		tile.push_back(tail);
		while (tile.size() != 0)
			byte_queue.push_back(tile.pop_front());
	endtask

	initial begin
		int made;
		int made_total;
		made_total = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Full-size tile: repeat and literal runs, then the input ends inside a literal run.
		push_byte(8'h80, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h33, 1'b0);
		push_byte(8'h05, 1'b0);
		push_byte(8'ha5, 1'b1);
		settle();

		// One-pixel planes: overrun, repeat, literal, overrun that completes the tile,
		// then bytes that are ignored until the last one restarts the decoder.
		write_reg(REG_TILE_WIDTH, 7'd1);
		write_reg(REG_TILE_HEIGHT, 7'd1);
		settle();
		push_byte(8'h81, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h7e, 1'b0);
		push_byte(8'h7f, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b1);
		settle();

		// Zero width counts as one: input ends on a header, then on a repeat value.
		write_reg(REG_TILE_WIDTH, 7'd0);
		write_reg(REG_TILE_HEIGHT, 7'd127);
		settle();
		push_byte(8'h85, 1'b1);
		push_byte(8'hbf, 1'b0);
		push_byte(8'hc3, 1'b1);
		settle();

		write_reg(REG_TILE_WIDTH, 7'd65);
		write_reg(REG_TILE_HEIGHT, 7'd0);
		settle();
		push_byte(8'hff, 1'b1);
		settle();

		write_reg(REG_TILE_WIDTH, 7'd127);
		write_reg(REG_TILE_HEIGHT, 7'd64);
		settle();
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b1);
		settle();

		// The receiver holds off for a long stretch while bytes keep coming.
		write_reg(REG_TILE_WIDTH, 7'd6);
		write_reg(REG_TILE_HEIGHT, 7'd6);
		settle();
		calm <= 1'b1;
		squeeze_req <= 1'b1;
		repeat (3) begin
			queue_tile(side_of(gen_w) * side_of(gen_h), made);
			made_total += made;
		end
		settle();

		while (made_total < RANDOM_BYTES) begin
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_TILE_WIDTH, pick_side());
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_TILE_HEIGHT, pick_side());
			settle();
			calm <= ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				queue_tile(side_of(gen_w) * side_of(gen_h), made);
				made_total += made;
			end
			settle();
		end

		if (fault_count == 0 && expected_runs.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

endmodule
